@@ hdl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared constants, codes and types of the LIFO replacement cache.
// ----------------------------------------------------------------------------
package lrc_pkg;

  // Storage geometry
  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W     = $clog2(ENTRIES + 1);

  // Port field widths
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LEVEL_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // One-cycle statistics update request
  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } stat_evt_t;

endpackage

@@ hdl/lrc_if.sv @@
// ----------------------------------------------------------------------------
// lrc_if
// Request and response channels of the LIFO replacement cache.
// ----------------------------------------------------------------------------
interface lrc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] key;
  logic [15:0] value_in;

  modport source (output valid, output op, output key, output value_in, input ready);
  modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

interface lrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] value_out;
  logic        evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic [4:0]  fill_level;

  modport source (output valid, output found, output value_out, output evicted,
                  output hit_total, output miss_total, output eviction_total,
                  output fill_level, input ready);
  modport sink   (input valid, input found, input value_out, input evicted,
                  input hit_total, input miss_total, input eviction_total,
                  input fill_level, output ready);
endinterface

@@ hdl/lrc_ram.sv @@
// ----------------------------------------------------------------------------
// lrc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

@@ hdl/lrc_stats.sv @@
// ----------------------------------------------------------------------------
// lrc_stats
// Saturating hit, miss and eviction counters.
// ----------------------------------------------------------------------------
module lrc_stats
  import lrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stat_evt_t        evt_i,
  output logic [CNT_W-1:0] hit_total_o,
  output logic [CNT_W-1:0] miss_total_o,
  output logic [CNT_W-1:0] eviction_total_o
);
  logic [CNT_W-1:0] hit_q, hit_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic [CNT_W-1:0] evict_q, evict_d;

  // hold at all-ones once reached
  always_comb begin
    hit_d   = (evt_i.hit   && !(&hit_q))   ? hit_q   + CNT_W'(1) : hit_q;
    miss_d  = (evt_i.miss  && !(&miss_q))  ? miss_q  + CNT_W'(1) : miss_q;
    evict_d = (evt_i.evict && !(&evict_q)) ? evict_q + CNT_W'(1) : evict_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else begin
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      evict_q <= evict_d;
    end
  end

  assign hit_total_o      = hit_q;
  assign miss_total_o     = miss_q;
  assign eviction_total_o = evict_q;
endmodule

@@ hdl/lifo_replacement_cache.sv @@
// Sequence: an empty cache goes from IDLE straight to FINISH; otherwise SCAN
//   compares the stored keys up to and including the first match (at most 16),
//   then FINISH loads the result register once the previous result has left.
// Throughput: one transaction at a time; the key scan reads one entry per cycle
//   from the key and value RAMs, which sets the rate.
// Reset: rst_ni clears fill level, counters and handshake state at once; the
//   capacity register returns to 16. Store contents are not cleared.
// ----------------------------------------------------------------------------
// lifo_replacement_cache
// Fully associative key/value cache with LIFO replacement. Keys and values
// live in two synchronous RAMs that are scanned from slot 0 upward.
// ----------------------------------------------------------------------------
module lifo_replacement_cache
  import lrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  lrc_req_if.sink          req_i,
  lrc_rsp_if.source        rsp_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                  state_q;
  logic [FILL_W-1:0]       fill_q;
  logic [CAP_W-1:0]        cap_q;
  logic                    out_valid_q;

  // Per-transaction payload (no reset needed)
  logic                    op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    found_q;
  logic [IDX_W-1:0]        hit_idx_q;
  logic [VALUE_BITS-1:0]   hit_val_q;
  logic                    out_found_q;
  logic [VAL_W-1:0]        out_value_q;
  logic                    out_evicted_q;

  // --------------------------------------------------------------------------
  // Control signals
  // --------------------------------------------------------------------------
  logic                    accept;
  logic                    out_free;
  logic                    fin_go;
  logic                    last_idx;
  logic                    match;
  logic                    full;
  logic [CAP_W-1:0]        eff_cap;
  logic                    is_put;
  logic                    do_evict;
  logic                    do_append;

  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    key_we;
  logic                    val_we;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_BITS-1:0]     key_rdata;
  logic [VALUE_BITS-1:0]   val_rdata;
  stat_evt_t               evt;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // The result register frees up when empty or when its transaction leaves now.
  assign out_free = !out_valid_q || rsp_o.ready;
  assign fin_go   = (state_q == ST_FINISH) && out_free;

  // Effective capacity: zero behaves as one, anything above the store as full size.
  always_comb begin
    eff_cap = cap_q;
    if (cap_q == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_q > CAP_W'(ENTRIES)) begin
      eff_cap = CAP_W'(ENTRIES);
    end
  end

  // Fill level at or above capacity counts as full, also after capacity is lowered.
  assign full = (CAP_W'(fill_q) >= eff_cap);

  assign last_idx = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
  assign match    = (key_rdata == key_q);

  // --------------------------------------------------------------------------
  // RAM access: read slot 0 on accept, then read ahead one slot per scan cycle.
  // Writes happen only in FINISH, when no read is in flight.
  // --------------------------------------------------------------------------
  assign rd_en   = accept || (state_q == ST_SCAN);
  assign rd_addr = accept ? '0 : idx_q + IDX_W'(1);

  assign is_put    = (op_q == OP_PUT);
  assign do_evict  = is_put && !found_q && full;
  assign do_append = is_put && !found_q && !full;

  assign val_we  = fin_go && is_put;
  assign key_we  = fin_go && is_put && !found_q;

  always_comb begin
    if (found_q) begin
      wr_addr = hit_idx_q;
    end else if (full) begin
      // replace the most recently filled slot
      wr_addr = IDX_W'(fill_q - FILL_W'(1));
    end else begin
      wr_addr = IDX_W'(fill_q);
    end
  end

  lrc_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lrc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_addr),
    .wdata_i (val_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  // --------------------------------------------------------------------------
  // Statistics: update once per transaction, when its result is loaded.
  // --------------------------------------------------------------------------
  always_comb begin
    evt.hit   = fin_go && !is_put && found_q;
    evt.miss  = fin_go && !is_put && !found_q;
    evt.evict = fin_go && do_evict;
  end

  lrc_stats u_stats (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt),
    .hit_total_o      (rsp_o.hit_total),
    .miss_total_o     (rsp_o.miss_total),
    .eviction_total_o (rsp_o.eviction_total)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (fin_go && do_append) begin
        fill_q <= fill_q + FILL_W'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // empty store: nothing to compare
            state_q <= (fill_q == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match || last_idx) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      key_q   <= req_i.key[KEY_BITS-1:0];
      val_q   <= req_i.value_in[VALUE_BITS-1:0];
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (match) begin
        found_q   <= 1'b1;
        hit_idx_q <= idx_q;
        hit_val_q <= val_rdata;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end

    if (fin_go) begin
      out_found_q   <= found_q;
      out_value_q   <= (!is_put && found_q) ? VAL_W'(hit_val_q) : '0;
      out_evicted_q <= do_evict;
    end
  end

  // Counters and fill level only move on a result load, which waits for the
  // previous result to leave, so the live values belong to the shown result.
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.value_out  = out_value_q;
  assign rsp_o.evicted    = out_evicted_q;
  assign rsp_o.fill_level = LEVEL_W'(fill_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(ENTRIES))
    else $error("fill level exceeds store size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (FILL_W'(idx_q) < fill_q))
    else $error("scan index beyond fill level");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((fill_q >= $past(fill_q)) && (fill_q <= $past(fill_q) + FILL_W'(1))))
    else $error("fill level moved by more than one or decreased");

  a_found_not_evicted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.found && rsp_o.evicted))
    else $error("result marks both found and evicted");

endmodule
